/* rtl/core/tls_pkg.sv */
// Shared types, character codes and format tables for the text line splitter.
`default_nettype none

package tls_pkg;

   // Fixed field widths of the result word.
   localparam int LEN_W     = 11;
   localparam int FMT_W     = 3;
   localparam int CNT_W     = 32;
   localparam int MAX_RES   = 4;
   localparam int RES_IDX_W = 2;
   localparam int RES_CNT_W = 3;
   localparam int RSP_DATA_W = 152;

   localparam logic [RES_CNT_W-1:0] RES_CNT_MAX = 3'd4;

   // Character codes.
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_EOF = 8'h1A;
   localparam logic [7:0] CHAR_RS  = 8'h1E;

   // Line-ending formats.
   localparam logic [FMT_W-1:0] FMT_NUL       = 3'd0;
   localparam logic [FMT_W-1:0] FMT_CR        = 3'd1;
   localparam logic [FMT_W-1:0] FMT_CRLF_EOF  = 3'd2;
   localparam logic [FMT_W-1:0] FMT_CRLF_EOF2 = 3'd3;
   localparam logic [FMT_W-1:0] FMT_RS        = 3'd4;
   localparam logic [FMT_W-1:0] FMT_CRLF      = 3'd5;
   localparam logic [FMT_W-1:0] FMT_LF        = 3'd6;
   localparam int               FMT_COUNT     = 7;

   typedef enum logic [1:0] {
      PH_SOL    = 2'd0,
      PH_INLINE = 2'd1,
      PH_GOTCR  = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      KIND_TEXT    = 3'd0,
      KIND_EOL     = 3'd1,
      KIND_SPLIT   = 3'd2,
      KIND_PARTIAL = 3'd3,
      KIND_DONE    = 3'd4
   } kind_type;

   typedef struct packed {
      logic [CNT_W-1:0] lines;
      logic [CNT_W-1:0] bytes;
      logic [CNT_W-1:0] nulls;
      logic [CNT_W-1:0] splits;
   } count_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data;
      logic [LEN_W-1:0] len;
      logic [FMT_W-1:0] fmt;
      count_type        cnt;
      logic             ended;
   } result_type;

   typedef struct packed {
      logic             ok;
      logic [FMT_W-1:0] idx;
   } match_type;

   function automatic logic [7:0] first_mark(input logic [FMT_W-1:0] fmt);
      logic [7:0] m;
      case (fmt)
         FMT_NUL: m = CHAR_NUL;
         FMT_RS:  m = CHAR_RS;
         FMT_LF:  m = CHAR_LF;
         default: m = CHAR_CR;
      endcase
      return m;
   endfunction

   function automatic logic is_two_byte(input logic [FMT_W-1:0] fmt);
      return (fmt == FMT_CRLF_EOF) || (fmt == FMT_CRLF_EOF2) || (fmt == FMT_CRLF);
   endfunction

   function automatic logic has_eof(input logic [FMT_W-1:0] fmt);
      return (fmt == FMT_CRLF_EOF) || (fmt == FMT_CRLF_EOF2);
   endfunction

   // First single-byte format whose ending is c.
   function automatic match_type single_match(input logic [7:0] c);
      match_type r;
      r = '0;
      for (int i = FMT_COUNT - 1; i >= 0; i--) begin
         if (!is_two_byte(FMT_W'(i)) && first_mark(FMT_W'(i)) == c) begin
            r.ok  = 1'b1;
            r.idx = FMT_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + CNT_W'(1);
   endfunction

endpackage

`default_nettype wire

/* rtl/core/tls_engine.sv */
// Combinational parse of one stream word: next parser state and its result burst.
`default_nettype none

module tls_engine #(
   parameter int MAX_LINE = 1024,
   parameter int CW       = 10
) (
   input  wire logic [7:0]                        in_byte,
   input  wire logic                              in_eos,
   input  wire tls_pkg::phase_type                cur_phase,
   input  wire logic [tls_pkg::FMT_W-1:0]         cur_fmt,
   input  wire logic [CW-1:0]                     cur_col,
   input  wire tls_pkg::count_type                cur_cnt,
   input  wire logic                              cur_ended,
   output tls_pkg::phase_type                     nxt_phase,
   output logic [tls_pkg::FMT_W-1:0]              nxt_fmt,
   output logic [CW-1:0]                          nxt_col,
   output tls_pkg::count_type                     nxt_cnt,
   output logic                                   nxt_ended,
   output logic [tls_pkg::RES_CNT_W-1:0]          res_num,
   output tls_pkg::result_type [tls_pkg::MAX_RES-1:0] res_list
);

   localparam logic [CW-1:0] COL_LIM = CW'(MAX_LINE - 1);

   always_comb begin
      tls_pkg::phase_type                     phase;
      logic [tls_pkg::FMT_W-1:0]              fmt;
      logic [CW-1:0]                          col;
      tls_pkg::count_type                     cnt;
      logic                                   ended;
      logic [tls_pkg::RES_CNT_W-1:0]          n;
      tls_pkg::result_type [tls_pkg::MAX_RES-1:0] res;
      logic [7:0]                             q [tls_pkg::MAX_RES];
      logic [tls_pkg::RES_CNT_W-1:0]          qn;
      logic                                   first;
      logic                                   stop;
      logic                                   finish;
      logic [7:0]                             c;
      logic [7:0]                             e0;
      logic [7:0]                             lit;
      logic                                   two;
      logic                                   eoln;
      logic                                   skip;
      tls_pkg::match_type                     m;

      phase  = cur_phase;
      fmt    = (cur_fmt > tls_pkg::FMT_LF) ? tls_pkg::FMT_LF : cur_fmt;
      col    = cur_col;
      cnt    = cur_cnt;
      ended  = cur_ended;
      n      = '0;
      res    = '0;
      qn     = '0;
      first  = 1'b1;
      stop   = 1'b0;
      finish = in_eos;
      c      = '0;
      e0     = '0;
      lit    = '0;
      two    = 1'b0;
      eoln   = 1'b0;
      skip   = 1'b0;
      m      = '0;
      for (int k = 0; k < tls_pkg::MAX_RES; k++) begin
         q[k] = '0;
      end

      if (phase != tls_pkg::PH_DONE) begin
         if (!in_eos) begin
            q[0] = in_byte;
            qn   = 3'd1;
            for (int it = 0; it < tls_pkg::MAX_RES; it++) begin
               if (!stop && qn != '0 && n < tls_pkg::RES_CNT_MAX) begin
                  // pop the head byte
                  c = q[0];
                  for (int k = 0; k < tls_pkg::MAX_RES - 1; k++) begin
                     q[k] = q[k + 1];
                  end
                  q[tls_pkg::MAX_RES - 1] = '0;
                  qn   = qn - 3'd1;
                  e0   = tls_pkg::first_mark(fmt);
                  two  = tls_pkg::is_two_byte(fmt);
                  lit  = c;
                  eoln = 1'b0;
                  skip = 1'b0;

                  if (tls_pkg::has_eof(fmt) && c == tls_pkg::CHAR_EOF) begin
                     finish = 1'b1;
                     stop   = 1'b1;
                  end else begin
                     if (first) begin
                        cnt.bytes = tls_pkg::sat_inc(cnt.bytes);
                        first     = 1'b0;
                     end
                     if (phase == tls_pkg::PH_GOTCR) begin
                        m = tls_pkg::single_match(e0);
                        if (two && c == tls_pkg::CHAR_LF) begin
                           eoln = 1'b1;
                        end else if (two && m.ok) begin
                           // lone CR: switch format, end line, replay this byte
                           fmt  = m.idx;
                           eoln = 1'b1;
                           for (int k = tls_pkg::MAX_RES - 1; k > 0; k--) begin
                              q[k] = q[k - 1];
                           end
                           q[0] = c;
                           qn   = qn + 3'd1;
                        end else begin
                           // keep the pending marker as text, replay this byte
                           phase = tls_pkg::PH_INLINE;
                           for (int k = tls_pkg::MAX_RES - 1; k > 0; k--) begin
                              q[k] = q[k - 1];
                           end
                           q[0] = c;
                           qn   = qn + 3'd1;
                           lit  = e0;
                        end
                     end else begin
                        m = tls_pkg::single_match(c);
                        if (c == e0) begin
                           if (!two) begin
                              eoln = 1'b1;
                           end else begin
                              phase = tls_pkg::PH_GOTCR;
                              skip  = 1'b1;
                           end
                        end else if (two && c == tls_pkg::CHAR_LF && m.ok) begin
                           fmt  = m.idx;
                           eoln = 1'b1;
                        end
                     end

                     if (!skip) begin
                        if (eoln || col >= COL_LIM) begin
                           cnt.lines = tls_pkg::sat_inc(cnt.lines);
                           if (!eoln) begin
                              cnt.splits = tls_pkg::sat_inc(cnt.splits);
                           end
                           if (n < tls_pkg::RES_CNT_MAX) begin
                              res[n[tls_pkg::RES_IDX_W-1:0]] = '{
                                 kind:  eoln ? tls_pkg::KIND_EOL : tls_pkg::KIND_SPLIT,
                                 data:  8'h00,
                                 len:   tls_pkg::LEN_W'(col),
                                 fmt:   fmt,
                                 cnt:   cnt,
                                 ended: ended};
                              n = n + 3'd1;
                           end
                           col   = '0;
                           phase = tls_pkg::PH_SOL;
                           if (!eoln && qn < 3'd3) begin
                              for (int k = tls_pkg::MAX_RES - 1; k > 0; k--) begin
                                 q[k] = q[k - 1];
                              end
                              q[0] = lit;
                              qn   = qn + 3'd1;
                           end
                        end else if (lit == tls_pkg::CHAR_NUL) begin
                           cnt.nulls = tls_pkg::sat_inc(cnt.nulls);
                        end else begin
                           col   = col + CW'(1);
                           phase = tls_pkg::PH_INLINE;
                           if (n < tls_pkg::RES_CNT_MAX) begin
                              res[n[tls_pkg::RES_IDX_W-1:0]] = '{
                                 kind:  tls_pkg::KIND_TEXT,
                                 data:  lit,
                                 len:   '0,
                                 fmt:   fmt,
                                 cnt:   cnt,
                                 ended: ended};
                              n = n + 3'd1;
                           end
                        end
                     end
                  end
               end
            end
         end

         // end of stream: flush an open line, then report done
         if (finish) begin
            if (phase != tls_pkg::PH_SOL) begin
               ended     = 1'b1;
               cnt.lines = tls_pkg::sat_inc(cnt.lines);
               if (n < tls_pkg::RES_CNT_MAX) begin
                  res[n[tls_pkg::RES_IDX_W-1:0]] = '{
                     kind:  tls_pkg::KIND_PARTIAL,
                     data:  8'h00,
                     len:   tls_pkg::LEN_W'(col),
                     fmt:   fmt,
                     cnt:   cnt,
                     ended: ended};
                  n = n + 3'd1;
               end
               col = '0;
            end
            phase = tls_pkg::PH_DONE;
            if (n < tls_pkg::RES_CNT_MAX) begin
               res[n[tls_pkg::RES_IDX_W-1:0]] = '{
                  kind:  tls_pkg::KIND_DONE,
                  data:  8'h00,
                  len:   '0,
                  fmt:   fmt,
                  cnt:   cnt,
                  ended: ended};
               n = n + 3'd1;
            end
         end
      end

      nxt_phase = phase;
      nxt_fmt   = fmt;
      nxt_col   = col;
      nxt_cnt   = cnt;
      nxt_ended = ended;
      res_num   = n;
      res_list  = res;
   end

endmodule

`default_nettype wire

/* rtl/core/text_line_splitter_eol_detect_core.sv */
// Top level of the text line splitter with end-of-line format detection.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  req     | in  | req_tvalid/req_tready  | tdata: byte; tlast: end of stream
//  rsp     | out | rsp_tvalid/rsp_tready  | tuser: kind; tdata: result; tlast: last
//  csr     | in  | csr_we (no stall)      | csr_wdata: starting line-ending format
//
// A word moves from the input register into the parser; the parser state (kept if
// a format write comes at the same time) and the whole result burst (up to four
// results) are registered together. The burst drains one result per cycle while
// rsp_tready is high; words that yield no result (dropped NUL, first half of CR LF)
// load no burst. The input register takes a new word while a burst is still draining.
// Synchronous active-high reset: parser at start of line, format LF, counters zero.
`default_nettype none

module text_line_splitter_eol_detect_core #(
   parameter int MAX_LINE = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // req_tdata: [7:0] in_byte
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,
   input  wire logic         req_tlast,
   // rsp_tdata: [7:0] data_byte, [18:8] line_length, [21:19] active_format,
   //   [53:22] line_total, [85:54] char_total, [117:86] null_total,
   //   [149:118] too_long_total, [150] last_line_incomplete, [151] zero
   // rsp_tuser: [2:0] kind
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [tls_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_wdata
);

   localparam int CW = (MAX_LINE > 2) ? $clog2(MAX_LINE) : 1;

   // input register
   logic       a_valid_ff;
   logic [7:0] a_byte_ff;
   logic       a_eos_ff;

   // parser state
   tls_pkg::phase_type            phase_ff, phase_in;
   logic [tls_pkg::FMT_W-1:0]     fmt_ff, fmt_in;
   logic [CW-1:0]                 col_ff, col_in;
   tls_pkg::count_type            cnt_ff, cnt_in;
   logic                          ended_ff, ended_in;

   // result burst buffer
   tls_pkg::result_type [tls_pkg::MAX_RES-1:0] b_res_ff;
   tls_pkg::result_type [tls_pkg::MAX_RES-1:0] b_res_in;
   logic [tls_pkg::RES_CNT_W-1:0] b_cnt_ff;
   logic [tls_pkg::RES_CNT_W-1:0] b_num_in;
   logic [tls_pkg::RES_IDX_W-1:0] b_idx_ff;

   logic                 rsp_fire;
   logic                 b_last;
   logic                 b_free;
   logic                 a_move;
   tls_pkg::result_type  cur_res;

   tls_engine #(
      .MAX_LINE (MAX_LINE),
      .CW       (CW)
   ) u_engine (
      .in_byte   (a_byte_ff),
      .in_eos    (a_eos_ff),
      .cur_phase (phase_ff),
      .cur_fmt   (fmt_ff),
      .cur_col   (col_ff),
      .cur_cnt   (cnt_ff),
      .cur_ended (ended_ff),
      .nxt_phase (phase_in),
      .nxt_fmt   (fmt_in),
      .nxt_col   (col_in),
      .nxt_cnt   (cnt_in),
      .nxt_ended (ended_in),
      .res_num   (b_num_in),
      .res_list  (b_res_in)
   );

   // Handshake: the burst frees up as its last result leaves.
   assign rsp_tvalid = (b_cnt_ff != '0);
   assign b_last     = ({1'b0, b_idx_ff} == (b_cnt_ff - 3'd1));
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign b_free     = !rsp_tvalid || (rsp_fire && b_last);
   assign a_move     = a_valid_ff && b_free;
   assign req_tready = !a_valid_ff || b_free;

   // Present the current burst entry.
   assign cur_res   = b_res_ff[b_idx_ff];
   assign rsp_tuser = cur_res.kind;
   assign rsp_tlast = b_last;
   assign rsp_tdata = {1'b0, cur_res.ended, cur_res.cnt.splits, cur_res.cnt.nulls,
                       cur_res.cnt.bytes, cur_res.cnt.lines, cur_res.fmt,
                       cur_res.len, cur_res.data};

   // Input register: hold a word until the parser takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         a_valid_ff <= 1'b1;
      end else if (a_move) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         a_byte_ff <= req_tdata;
         a_eos_ff  <= req_tlast;
      end
   end

   // Parser state; a format write also makes that format active.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tls_pkg::PH_SOL;
         fmt_ff   <= tls_pkg::FMT_LF;
         col_ff   <= '0;
         cnt_ff   <= '0;
         ended_ff <= 1'b0;
      end else if (csr_we) begin
         if (csr_wdata <= tls_pkg::FMT_LF) begin
            fmt_ff <= csr_wdata;
         end
      end else if (a_move) begin
         phase_ff <= phase_in;
         fmt_ff   <= fmt_in;
         col_ff   <= col_in;
         cnt_ff   <= cnt_in;
         ended_ff <= ended_in;
      end
   end

   // Burst control: load a new burst, or advance through the current one.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_cnt_ff <= '0;
         b_idx_ff <= '0;
      end else if (a_move && b_num_in != '0) begin
         b_cnt_ff <= b_num_in;
         b_idx_ff <= '0;
      end else if (rsp_fire) begin
         if (b_last) begin
            b_cnt_ff <= '0;
            b_idx_ff <= '0;
         end else begin
            b_idx_ff <= b_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_move && b_num_in != '0) begin
         b_res_ff <= b_res_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/tls_checker.sv */
// Port-level checks for the line splitter, bound to the top level.
`default_nettype none

module tls_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [tls_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [2:0]   rsp_tuser,
   input wire logic         rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // with no result pending the input is always open
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no result pending");

   // done always closes its burst
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == tls_pkg::KIND_DONE |-> rsp_tlast)
      else $error("done result not last of its burst");

   // text results carry a nonzero byte and no length
   a_text_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == tls_pkg::KIND_TEXT |->
         rsp_tdata[7:0] != 8'h00 && rsp_tdata[18:8] == 11'd0)
      else $error("malformed text result");

   // an incomplete last line sets the flag and is followed by done
   a_partial: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == tls_pkg::KIND_PARTIAL |-> rsp_tdata[150] && !rsp_tlast)
      else $error("incomplete line result malformed");

endmodule

bind text_line_splitter_eol_detect_core tls_checker u_tls_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

/* tb/text_line_splitter_eol_detect_core_tb.sv */
// Self-checking testbench for the text line splitter with end-of-line format detection.
`default_nettype none

module text_line_splitter_eol_detect_core_tb;

   localparam int MAX_LINE    = 1024;
   localparam int HOLD_CYCLES = 300;   // one long receiver hold-off
   localparam int SETTLE      = 4;     // quiet cycles before a register write
   localparam int TAIL        = 20;    // quiet cycles before the verdict
   localparam int REPORT_MAX  = 10;
   localparam int LINE_WORDS  = 28;    // at least this many words per format in the random test

   // One expected or observed result word, split into its fields.
   typedef struct packed {
      tls_pkg::kind_type                 kind;
      logic [7:0]                        data;
      logic [tls_pkg::LEN_W-1:0]         len;
      logic [tls_pkg::FMT_W-1:0]         fmt;
      logic [tls_pkg::CNT_W-1:0]         lines;
      logic [tls_pkg::CNT_W-1:0]         bytes;
      logic [tls_pkg::CNT_W-1:0]         nulls;
      logic [tls_pkg::CNT_W-1:0]         splits;
      logic                              ended;
      logic                              last;
   } line_event_type;

   // ---------------------------------------------------------------------------
   // Clock, reset and block ports; every input is known from time zero.
   // ---------------------------------------------------------------------------
   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata  = 8'h00;
   logic                           req_tlast  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [tls_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]                     rsp_tuser;
   logic                           rsp_tlast;
   logic                           csr_we     = 1'b0;
   logic [2:0]                     csr_wdata  = 3'd0;

   always #4 clock = ~clock;

   text_line_splitter_eol_detect_core #(
      .MAX_LINE(MAX_LINE)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Line predictor state: mirrors the parser after every accepted word.
   // ---------------------------------------------------------------------------
   logic [tls_pkg::FMT_W-1:0] cur_fmt     = tls_pkg::FMT_LF;
   tls_pkg::phase_type        parse_ph    = tls_pkg::PH_SOL;
   logic [tls_pkg::LEN_W-1:0] col_cnt     = '0;
   logic [tls_pkg::CNT_W-1:0] line_cnt    = '0;
   logic [tls_pkg::CNT_W-1:0] byte_cnt    = '0;
   logic [tls_pkg::CNT_W-1:0] nul_cnt     = '0;
   logic [tls_pkg::CNT_W-1:0] split_cnt   = '0;
   logic                      midline_end = 1'b0;

   line_event_type events_due [$];                     // results still owed by the block
   line_event_type burst_buf [0:tls_pkg::MAX_RES-1];   // results of the word being parsed
   int             burst_n;
   logic [7:0]     redo_buf [0:3];                     // bytes waiting to be parsed (again)
   int             redo_n;

   int mismatch_cnt = 0;
   int words_sent   = 0;

   // Sender pacing: bursts of random length, separated by random gaps no longer than gap_max.
   int burst_left = 0;
   int gap_max    = 4;

   // Receiver pacing; hold_seq bumps request one long hold-off.
   logic [15:0] rx_cycle  = '0;
   logic [3:0]  hold_seq  = '0;
   logic [3:0]  hold_seen = '0;
   int          hold_left = 0;

   // ---------------------------------------------------------------------------
   // Format table: line-end byte, CR LF pairing, end-of-file byte.
   // ---------------------------------------------------------------------------
   function automatic logic [7:0] end_mark(input logic [tls_pkg::FMT_W-1:0] f);
      logic [7:0] m;
      case (f)
         tls_pkg::FMT_NUL: m = tls_pkg::CHAR_NUL;
         tls_pkg::FMT_RS:  m = tls_pkg::CHAR_RS;
         tls_pkg::FMT_LF:  m = tls_pkg::CHAR_LF;
         default:          m = tls_pkg::CHAR_CR;
      endcase
      return m;
   endfunction

   function automatic logic paired(input logic [tls_pkg::FMT_W-1:0] f);
      return f inside {tls_pkg::FMT_CRLF_EOF, tls_pkg::FMT_CRLF_EOF2, tls_pkg::FMT_CRLF};
   endfunction

   function automatic logic has_eof_byte(input logic [tls_pkg::FMT_W-1:0] f);
      return f inside {tls_pkg::FMT_CRLF_EOF, tls_pkg::FMT_CRLF_EOF2};
   endfunction

   // Lowest single-byte format that ends lines on c.
   function automatic tls_pkg::match_type lone_target(input logic [7:0] c);
      tls_pkg::match_type m;
      m = '0;
      for (int i = 0; i < tls_pkg::FMT_COUNT; i++) begin
         if (!m.ok && !paired(tls_pkg::FMT_W'(i)) && end_mark(tls_pkg::FMT_W'(i)) == c) begin
            m.ok  = 1'b1;
            m.idx = tls_pkg::FMT_W'(i);
         end
      end
      return m;
   endfunction

   function automatic logic [tls_pkg::CNT_W-1:0] sat_up(input logic [tls_pkg::CNT_W-1:0] v);
      return (v == {tls_pkg::CNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // Predictor: parse one accepted word into up to four results.
   // ---------------------------------------------------------------------------
   task automatic record_event(input tls_pkg::kind_type k, input logic [7:0] d,
                               input logic [tls_pkg::LEN_W-1:0] n);
      line_event_type e;
      e.kind   = k;
      e.data   = d;
      e.len    = n;
      e.fmt    = cur_fmt;
      e.lines  = line_cnt;
      e.bytes  = byte_cnt;
      e.nulls  = nul_cnt;
      e.splits = split_cnt;
      e.ended  = midline_end;
      e.last   = 1'b0;
      if (burst_n < tls_pkg::MAX_RES) begin
         burst_buf[burst_n] = e;
         burst_n++;
      end
   endtask

   // Put a byte back at the head of the parse queue.
   task automatic requeue(input logic [7:0] c);
      for (int k = redo_n; k > 0; k--) redo_buf[k] = redo_buf[k-1];
      redo_buf[0] = c;
      redo_n++;
   endtask

   // Report an unfinished line, then the end of the stream.
   task automatic close_stream();
      if (parse_ph != tls_pkg::PH_SOL) begin
         midline_end = 1'b1;
         line_cnt    = sat_up(line_cnt);
         record_event(tls_pkg::KIND_PARTIAL, 8'h00, col_cnt);
         col_cnt = '0;
      end
      parse_ph = tls_pkg::PH_DONE;
      record_event(tls_pkg::KIND_DONE, 8'h00, '0);
   endtask

   task automatic compute_line_events(input logic [7:0] b, input logic eos);
      int                        guard;
      logic                      first_pass;
      logic                      eoln;
      logic [7:0]                c;
      logic [7:0]                e0;
      logic [7:0]                lit;
      logic [tls_pkg::FMT_W-1:0] f;
      tls_pkg::match_type        m;
      line_event_type            e;
      burst_n = 0;
      // Once the stream is done, everything is swallowed silently.
      if (parse_ph != tls_pkg::PH_DONE) begin
         if (eos) begin
            close_stream();
         end else begin
            redo_buf[0] = b;
            redo_n      = 1;
            guard       = 0;
            first_pass  = 1'b1;
            while (redo_n > 0 && burst_n < tls_pkg::MAX_RES && guard < 8) begin
               c     = redo_buf[0];
               f     = cur_fmt;
               e0    = end_mark(f);
               lit   = c;
               eoln  = 1'b0;
               guard++;
               for (int k = 1; k < redo_n; k++) redo_buf[k-1] = redo_buf[k];
               redo_n--;
               if (has_eof_byte(f) && c == tls_pkg::CHAR_EOF) begin
                  close_stream();
                  break;
               end
               // A byte parsed again still counts once.
               if (first_pass) begin
                  byte_cnt   = sat_up(byte_cnt);
                  first_pass = 1'b0;
               end
               if (parse_ph == tls_pkg::PH_GOTCR) begin
                  m = lone_target(e0);
                  if (paired(f) && c == tls_pkg::CHAR_LF) begin
                     eoln = 1'b1;
                  end else if (paired(f) && m.ok) begin
                     // Lone CR: drop to the single-byte format, parse c again.
                     cur_fmt = m.idx;
                     eoln    = 1'b1;
                     requeue(c);
                  end else begin
                     // Unmatched first marker turns into text.
                     parse_ph = tls_pkg::PH_INLINE;
                     requeue(c);
                     lit = e0;
                  end
               end else if (c == e0) begin
                  if (!paired(f)) begin
                     eoln = 1'b1;
                  end else begin
                     parse_ph = tls_pkg::PH_GOTCR;
                     continue;
                  end
               end else if (paired(f) && c == tls_pkg::CHAR_LF) begin
                  // Lone LF in a CR LF format switches the format.
                  m = lone_target(c);
                  if (m.ok) begin
                     cur_fmt = m.idx;
                     eoln    = 1'b1;
                  end
               end
               if (eoln || col_cnt >= tls_pkg::LEN_W'(MAX_LINE - 1)) begin
                  line_cnt = sat_up(line_cnt);
                  if (!eoln) split_cnt = sat_up(split_cnt);
                  record_event(eoln ? tls_pkg::KIND_EOL : tls_pkg::KIND_SPLIT, 8'h00,
                               col_cnt);
                  col_cnt  = '0;
                  parse_ph = tls_pkg::PH_SOL;
                  if (!eoln && redo_n < 3) requeue(lit);
               end else if (lit == tls_pkg::CHAR_NUL) begin
                  nul_cnt = sat_up(nul_cnt);
               end else begin
                  col_cnt  = col_cnt + 1'b1;
                  parse_ph = tls_pkg::PH_INLINE;
                  record_event(tls_pkg::KIND_TEXT, lit, '0);
               end
            end
         end
      end
      for (int i = 0; i < burst_n; i++) begin
         e      = burst_buf[i];
         e.last = (i == burst_n - 1);
         events_due.push_back(e);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sender: offer one word, hold it until accepted, then predict its results.
   // Valid stays high on return so the next word follows without a bubble;
   // any other wait must lower valid first.
   // ---------------------------------------------------------------------------
   task automatic send_word(input logic [7:0] b, input logic eos);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      compute_line_events(b, eos);
   endtask

   // Drop valid, wait for every owed result, then let the block settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (events_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write the starting format while the block is idle; values above 6 are ignored.
   task automatic write_format(input logic [2:0] v);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      if (v <= tls_pkg::FMT_LF) begin
         cur_fmt = v;
      end
      csr_we <= 1'b0;
   endtask

   // Any byte except one that would end the stream in the active format.
   function automatic logic [7:0] any_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (has_eof_byte(cur_fmt) && b == tls_pkg::CHAR_EOF);
      return b;
   endfunction

   // Plain text: no NUL and no marker of any format.
   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255));
      while (b inside {tls_pkg::CHAR_LF, tls_pkg::CHAR_CR, tls_pkg::CHAR_EOF,
                       tls_pkg::CHAR_RS});
      return b;
   endfunction

   // ---------------------------------------------------------------------------
   // Receiver: the ready pattern is chosen by rx_cycle[8:6]; a bump of hold_seq holds off.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 16'd1;
      if (hold_seen != hold_seq) begin
         hold_seen  <= hold_seq;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_cycle[8:6])
            3'd0, 3'd1: rsp_tready <= 1'b1;
            3'd2:       rsp_tready <= ($urandom_range(0, 3) != 0);
            3'd3:       rsp_tready <= ($urandom_range(0, 3) == 0);
            3'd4:       rsp_tready <= (rx_cycle[1:0] != 2'b11);
            3'd5:       rsp_tready <= rx_cycle[2];
            default:    rsp_tready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Checker: every accepted result word against the oldest expectation.
   // ---------------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         mismatch_cnt++;
         if (mismatch_cnt <= REPORT_MAX)
            $display("%0t: %s differs: expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   task automatic check_word();
      line_event_type want;
      line_event_type got;
      got.kind   = tls_pkg::kind_type'(rsp_tuser);
      got.data   = rsp_tdata[7:0];
      got.len    = rsp_tdata[18:8];
      got.fmt    = rsp_tdata[21:19];
      got.lines  = rsp_tdata[53:22];
      got.bytes  = rsp_tdata[85:54];
      got.nulls  = rsp_tdata[117:86];
      got.splits = rsp_tdata[149:118];
      got.ended  = rsp_tdata[150];
      got.last   = rsp_tlast;
      if (events_due.size() == 0) begin
         mismatch_cnt++;
         if (mismatch_cnt <= REPORT_MAX)
            $display("%0t: result of kind %0d arrived with nothing expected",
                     $time, rsp_tuser);
      end else begin
         want = events_due.pop_front();
         compare_field("kind",           32'(want.kind),   32'(got.kind));
         compare_field("data_byte",      32'(want.data),   32'(got.data));
         compare_field("line_length",    32'(want.len),    32'(got.len));
         compare_field("active_format",  32'(want.fmt),    32'(got.fmt));
         compare_field("last_of_run",    32'(want.last),   32'(got.last));
         compare_field("line_total",     want.lines,       got.lines);
         compare_field("char_total",     want.bytes,       got.bytes);
         compare_field("null_total",     want.nulls,       got.nulls);
         compare_field("too_long_total", want.splits,      got.splits);
         compare_field("last_line_incomplete", 32'(want.ended), 32'(got.ended));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_word();
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset format LF: byte extremes, empty line, dropped NUL, 0x1A as text.
   task automatic test_lf_lines();
      send_word(8'h41, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(tls_pkg::CHAR_LF, 1'b0);
      send_word(tls_pkg::CHAR_LF, 1'b0);
      send_word(tls_pkg::CHAR_NUL, 1'b0);
      send_word(8'h01, 1'b0);
      send_word(tls_pkg::CHAR_EOF, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'h7F, 1'b0);
      send_word(tls_pkg::CHAR_LF, 1'b0);
   endtask

   // CR LF pair, lone CR (switch to CR, reparse), lone LF (switch to LF), CR CR.
   task automatic test_crlf_switching();
      write_format(tls_pkg::FMT_CRLF);
      send_word(8'h78, 1'b0);
      send_word(tls_pkg::CHAR_CR, 1'b0);
      send_word(tls_pkg::CHAR_LF, 1'b0);
      send_word(8'h79, 1'b0);
      send_word(tls_pkg::CHAR_CR, 1'b0);
      send_word(8'h7A, 1'b0);
      write_format(tls_pkg::FMT_CRLF);
      send_word(8'h77, 1'b0);
      send_word(tls_pkg::CHAR_LF, 1'b0);
      write_format(tls_pkg::FMT_CRLF);
      send_word(tls_pkg::CHAR_CR, 1'b0);
      send_word(tls_pkg::CHAR_CR, 1'b0);
   endtask

   // NUL, RS and CR endings; a write of 7 must leave the format alone.
   task automatic test_single_byte_formats();
      write_format(tls_pkg::FMT_NUL);
      send_word(8'h61, 1'b0);
      send_word(tls_pkg::CHAR_NUL, 1'b0);
      send_word(tls_pkg::CHAR_LF, 1'b0);
      send_word(tls_pkg::CHAR_NUL, 1'b0);
      write_format(tls_pkg::FMT_RS);
      send_word(8'h62, 1'b0);
      send_word(tls_pkg::CHAR_RS, 1'b0);
      write_format(tls_pkg::FMT_CR);
      send_word(8'h63, 1'b0);
      send_word(tls_pkg::CHAR_CR, 1'b0);
      send_word(tls_pkg::CHAR_NUL, 1'b0);
      write_format(3'd7);
      send_word(8'h64, 1'b0);
      send_word(tls_pkg::CHAR_CR, 1'b0);
   endtask

   // Hold the receiver off for a long stretch while words keep coming,
   // so the block fills up and stalls its input.
   task automatic test_output_backpressure();
      write_format(tls_pkg::FMT_LF);
      gap_max  = 0;
      hold_seq <= hold_seq + 4'd1;
      for (int i = 0; i < 48; i++)
         send_word((i % 6 == 5) ? tls_pkg::CHAR_LF : text_byte(), 1'b0);
   endtask

   // One line of random content, mostly well formed for the active format.
   task automatic send_random_line();
      int len;
      int r;
      len = $urandom_range(0, 12);
      repeat (len) begin
         r = $urandom_range(0, 19);
         if (r == 0)      send_word(tls_pkg::CHAR_NUL, 1'b0);
         else if (r < 3)  send_word(any_byte(), 1'b0);
         else             send_word(text_byte(), 1'b0);
      end
      r = $urandom_range(0, 9);
      if (paired(cur_fmt)) begin
         if (r < 7) begin
            send_word(tls_pkg::CHAR_CR, 1'b0);
            send_word(tls_pkg::CHAR_LF, 1'b0);
         end else if (r == 7) begin
            send_word(tls_pkg::CHAR_CR, 1'b0);
         end else if (r == 8) begin
            send_word(tls_pkg::CHAR_LF, 1'b0);
         end else begin
            send_word(tls_pkg::CHAR_CR, 1'b0);
            send_word(tls_pkg::CHAR_CR, 1'b0);
         end
      end else if (r < 8) begin
         send_word(end_mark(cur_fmt), 1'b0);
      end else begin
         case ($urandom_range(0, 3))
            0:       send_word(tls_pkg::CHAR_CR, 1'b0);
            1:       send_word(tls_pkg::CHAR_LF, 1'b0);
            2:       send_word(tls_pkg::CHAR_RS, 1'b0);
            default: send_word(tls_pkg::CHAR_NUL, 1'b0);
         endcase
      end
   endtask

   // Random lines under every format in turn, with changing sender pacing.
   task automatic test_random_text();
      logic [tls_pkg::FMT_W-1:0] f;
      int                        start;
      for (int p = 0; p < tls_pkg::FMT_COUNT; p++) begin
         case (p)
            0:       f = tls_pkg::FMT_LF;
            1:       f = tls_pkg::FMT_NUL;
            2:       f = tls_pkg::FMT_CRLF_EOF;
            3:       f = tls_pkg::FMT_CRLF;
            4:       f = tls_pkg::FMT_CR;
            5:       f = tls_pkg::FMT_RS;
            default: f = tls_pkg::FMT_CRLF_EOF2;
         endcase
         write_format(f);
         gap_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 8);
         start   = words_sent;
         while (words_sent - start < LINE_WORDS) send_random_line();
      end
   endtask

   // End-of-file byte after a pending CR: the partial line excludes the CR,
   // then the stream is done and later words, end of stream too, give nothing.
   task automatic test_end_of_file();
      gap_max = 3;
      write_format(tls_pkg::FMT_LF);
      send_word(tls_pkg::CHAR_LF, 1'b0);
      write_format(tls_pkg::FMT_CRLF_EOF2);
      send_word(8'h61, 1'b0);
      send_word(8'h62, 1'b0);
      send_word(tls_pkg::CHAR_CR, 1'b0);
      send_word(tls_pkg::CHAR_EOF, 1'b0);
      send_word(8'h71, 1'b0);
      send_word(tls_pkg::CHAR_CR, 1'b0);
      send_word(8'h00, 1'b1);
   endtask

   // ---------------------------------------------------------------------------
   // Sequence: reset once, run the tests, drain, then give the verdict.
   // ---------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_lf_lines();
      test_crlf_switching();
      test_single_byte_formats();
      test_output_backpressure();
      test_random_text();
      test_end_of_file();
      wait_idle();
      repeat (TAIL) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #8_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
rtl/core/tls_pkg.sv
rtl/core/tls_engine.sv
rtl/core/text_line_splitter_eol_detect_core.sv
rtl/core/tls_checker.sv
tb/text_line_splitter_eol_detect_core_tb.sv
